// File: rtl/core/tsst_pkg.sv
// Shared types and constants for the time-slot scheduler table.
// Depends on nothing; used by the controller, datapath and top level.
package tsst_pkg;

   localparam logic [1:0] KIND_SET_PARAMS = 2'd0;
   localparam logic [1:0] KIND_MARK_READY = 2'd1;
   localparam logic [1:0] KIND_PICK_NEXT  = 2'd2;
   localparam logic [1:0] KIND_UNUSED     = 2'd3;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_LOAD   = 8'b00000010,
      ST_SRCH_U = 8'b00000100,
      ST_SRCH_L = 8'b00001000,
      ST_COMMIT = 8'b00010000,
      ST_SCAN   = 8'b00100000,
      ST_RESULT = 8'b01000000,
      ST_OUT    = 8'b10000000
   } state_type;

   typedef struct packed {
      logic load;        // latch request, read held set
      logic srch_start;  // reset rotation counter, select blocking mask
      logic srch_lock;   // block on locked slots instead of used slots
      logic srch_step;   // test one rotation
      logic commit;      // update masks and slot ownership
      logic scan_start;
      logic scan_step;   // look at one slot
      logic mark_ready;
      logic finish;      // form the result beat
      logic fail;        // no rotation fits
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       part_ok;
      logic       yield_take;
      logic       srch_hit;
      logic       srch_done;
      logic       scan_hit;
      logic       scan_done;
   } sts_type;

endpackage

// File: rtl/core/tsst_ctrl.sv
// Controller state machine for the time-slot scheduler table.
// Depends on tsst_pkg; drives commands into tsst_dp.
module tsst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tsst_pkg::sts_type  sts,
   output tsst_pkg::cmd_type  cmd
);

   tsst_pkg::state_type state_ff, state_in;
   logic                fail_ff, fail_in;

   assign req_stall = (state_ff != tsst_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == tsst_pkg::ST_OUT);

   always_comb begin
      state_in = state_ff;
      fail_in  = fail_ff;
      cmd      = '0;
      cmd.fail = fail_ff;
      case (state_ff)
         tsst_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = tsst_pkg::ST_LOAD;
            end
         end
         tsst_pkg::ST_LOAD: begin
            fail_in = 1'b0;
            if (sts.kind == tsst_pkg::KIND_SET_PARAMS && sts.part_ok) begin
               cmd.srch_start = 1'b1;
               state_in = tsst_pkg::ST_SRCH_U;
            end else if (sts.kind == tsst_pkg::KIND_MARK_READY && sts.part_ok) begin
               cmd.mark_ready = 1'b1;
               state_in = tsst_pkg::ST_RESULT;
            end else if (sts.kind == tsst_pkg::KIND_PICK_NEXT && !sts.yield_take) begin
               cmd.scan_start = 1'b1;
               state_in = tsst_pkg::ST_SCAN;
            end else begin
               state_in = tsst_pkg::ST_RESULT;
            end
         end
         tsst_pkg::ST_SRCH_U: begin
            if (sts.srch_hit) begin
               state_in = tsst_pkg::ST_COMMIT;
            end else if (sts.srch_done) begin
               cmd.srch_start = 1'b1;
               cmd.srch_lock  = 1'b1;
               state_in = tsst_pkg::ST_SRCH_L;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         tsst_pkg::ST_SRCH_L: begin
            if (sts.srch_hit) begin
               state_in = tsst_pkg::ST_COMMIT;
            end else if (sts.srch_done) begin
               fail_in  = 1'b1;
               state_in = tsst_pkg::ST_RESULT;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         tsst_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = tsst_pkg::ST_RESULT;
         end
         tsst_pkg::ST_SCAN: begin
            if (sts.scan_hit || sts.scan_done) begin
               state_in = tsst_pkg::ST_RESULT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         tsst_pkg::ST_RESULT: begin
            cmd.finish = 1'b1;
            state_in = tsst_pkg::ST_OUT;
         end
         tsst_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = tsst_pkg::ST_IDLE;
         end
         default: state_in = tsst_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsst_pkg::ST_IDLE;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

// File: rtl/core/tsst_dp.sv
// Datapath of the time-slot scheduler table: held masks, rotation search and slot scan.
// Depends on tsst_pkg; sequenced by tsst_ctrl.
module tsst_dp #(
   parameter int SLOTS      = 64,
   parameter int PARTITIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tsst_pkg::cmd_type       cmd,
   output tsst_pkg::sts_type       sts,
   input  logic [1:0]              req_kind,
   input  logic [3:0]              req_partition,
   input  logic [63:0]             req_required_mask,
   input  logic [63:0]             req_desired_mask,
   input  logic                    req_yield_valid,
   input  logic [3:0]              req_yield_target,
   output logic                    rsp_status,
   output logic [3:0]              rsp_next_partition,
   output logic [63:0]             rsp_held_mask
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam logic [SW:0] SLOTS_C = (SW + 1)'(SLOTS);

   // a slot's owner is the one partition whose held mask has its bit set
   logic [SLOTS-1:0] used_ff, locked_ff;
   logic [SW-1:0]    cur_ff;
   logic [SLOTS-1:0] held_ff [PARTITIONS];
   logic [SLOTS-1:0] reqset_ff [PARTITIONS];
   logic [PARTITIONS-1:0] ready_ff;

   logic [1:0]       kind_ff;
   logic [3:0]       part_ff;
   logic [PW-1:0]    pidx;
   logic             pok_ff, ytake_ff;
   logic [3:0]       yt_ff;
   logic [SLOTS-1:0] req_ff, des_ff, mine_ff, block_ff;
   logic [SW:0]      cnt_ff;
   logic [3:0]       next_ff;
   logic [SW-1:0]    slot_ff;
   logic             hit_ff;

   logic             pok_c;
   assign pok_c = (32'(req_partition) < PARTITIONS);
   assign pidx  = PW'(part_ff);

   // one rotation of the working pattern per search step
   function automatic logic [SLOTS-1:0] rot1(input logic [SLOTS-1:0] x);
      return {x[SLOTS-2:0], x[SLOTS-1]};
   endfunction

   logic [SW-1:0]         nslot;
   logic [PARTITIONS-1:0] run_vec;
   logic [3:0]            so_part;
   logic                  so_ok;
   assign nslot = (32'(slot_ff) == SLOTS - 1) ? '0 : slot_ff + SW'(1);

   always_comb begin
      so_part = '0;
      for (int i = 0; i < PARTITIONS; i++) begin
         run_vec[i] = held_ff[i][nslot] & ready_ff[i];
         if (run_vec[i]) so_part = 4'(i);
      end
   end
   assign so_ok = |run_vec;

   // required slots lock before desired ones are filtered
   logic [SLOTS-1:0] lock_nx, claim;
   assign lock_nx = (locked_ff & ~(mine_ff & reqset_ff[pidx])) | req_ff;
   assign claim   = req_ff | (des_ff & ~lock_nx);

   assign sts.kind       = kind_ff;
   assign sts.part_ok    = pok_ff;
   assign sts.yield_take = ytake_ff;
   assign sts.srch_hit   = ((req_ff & block_ff) == '0) && (cnt_ff < SLOTS_C);
   assign sts.srch_done  = (cnt_ff >= SLOTS_C);
   assign sts.scan_hit   = hit_ff;
   assign sts.scan_done  = (cnt_ff >= SLOTS_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         locked_ff    <= '0;
         cur_ff       <= '0;
         ready_ff     <= '0;
         for (int i = 0; i < PARTITIONS; i++) begin
            held_ff[i]   <= '0;
            reqset_ff[i] <= '0;
         end
      end else begin
         if (cmd.mark_ready) ready_ff[pidx] <= 1'b1;
         if (cmd.commit) begin
            locked_ff       <= lock_nx;
            used_ff         <= (used_ff & ~mine_ff) | claim;
            reqset_ff[pidx] <= req_ff;
            // old slots drop, claimed slots leave any other owner
            for (int i = 0; i < PARTITIONS; i++)
               held_ff[i] <= (i == int'(pidx)) ? claim : (held_ff[i] & ~claim);
         end
         if (cmd.scan_step && so_ok) cur_ff <= nslot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         part_ff  <= req_partition;
         pok_ff   <= pok_c;
         yt_ff    <= req_yield_target;
         ytake_ff <= req_yield_valid && (req_yield_target != req_partition)
                     && (32'(req_yield_target) < PARTITIONS);
         req_ff   <= req_required_mask[SLOTS-1:0];
         des_ff   <= req_desired_mask[SLOTS-1:0];
         mine_ff  <= pok_c ? held_ff[PW'(req_partition)] : '0;
      end
      if (cmd.srch_start) begin
         cnt_ff   <= '0;
         block_ff <= cmd.srch_lock ? (locked_ff & ~mine_ff) : (used_ff & ~mine_ff);
      end
      if (cmd.srch_step) begin
         req_ff <= rot1(req_ff);
         des_ff <= rot1(des_ff);
         cnt_ff <= cnt_ff + (SW + 1)'(1);
      end
      if (cmd.scan_start) begin
         cnt_ff  <= '0;
         slot_ff <= cur_ff;
         hit_ff  <= 1'b0;
         next_ff <= part_ff;
      end
      if (cmd.scan_step) begin
         cnt_ff  <= cnt_ff + (SW + 1)'(1);
         slot_ff <= nslot;
         if (so_ok) begin
            hit_ff  <= 1'b1;
            next_ff <= so_part;
         end
      end
      if (cmd.finish) begin
         rsp_status         <= cmd.fail;
         rsp_next_partition <= (kind_ff == tsst_pkg::KIND_PICK_NEXT)
                               ? (ytake_ff ? yt_ff : next_ff) : '0;
         rsp_held_mask      <= (pok_ff && kind_ff != tsst_pkg::KIND_UNUSED)
                               ? 64'(held_ff[pidx]) : '0;
      end
   end

endmodule

// File: rtl/core/time_slot_scheduler_table_unit.sv
// Time-slot scheduler table: one request in, one result beat out.
// Set-params tests rotations against used slots, then, if none fits, against locked
// slots, and commits the first fit; pick-next scans the slots unless a yield is taken;
// other kinds go straight to the result. One request in flight; the next is accepted the cycle
// after the result beat leaves. Reset: synchronous, clears the slot masks, flags and owners.
module time_slot_scheduler_table_unit #(
   parameter int SLOTS      = 64,
   parameter int PARTITIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_partition,
   input  logic [63:0] req_required_mask,
   input  logic [63:0] req_desired_mask,
   input  logic        req_yield_valid,
   input  logic [3:0]  req_yield_target,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [3:0]  rsp_next_partition,
   output logic [63:0] rsp_held_mask
);

   tsst_pkg::cmd_type cmd;
   tsst_pkg::sts_type sts;

   tsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsst_dp #(.SLOTS(SLOTS), .PARTITIONS(PARTITIONS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_kind           (req_kind),
      .req_partition      (req_partition),
      .req_required_mask  (req_required_mask),
      .req_desired_mask   (req_desired_mask),
      .req_yield_valid    (req_yield_valid),
      .req_yield_target   (req_yield_target),
      .rsp_status         (rsp_status),
      .rsp_next_partition (rsp_next_partition),
      .rsp_held_mask      (rsp_held_mask)
   );

endmodule

// File: tb/time_slot_scheduler_table_unit_tb.sv
// Testbench for the time-slot scheduler table: predicts slot ownership, rotation search
// and round-robin pick-next in its own model and checks every result beat field by field.
// Depends on tsst_pkg and time_slot_scheduler_table_unit.
module time_slot_scheduler_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 64;
   localparam int NPART = 16;
   localparam int HOLD_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  partition;
      logic [63:0] required_mask;
      logic [63:0] desired_mask;
      logic        yield_valid;
      logic [3:0]  yield_target;
   } request_type;

   typedef struct {
      logic        status;
      logic [3:0]  next_partition;
      logic [63:0] held_mask;
   } grant_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_kind = 0;
   logic [3:0] req_partition = 0;
   logic [63:0] req_required_mask = 0;
   logic [63:0] req_desired_mask = 0;
   logic req_yield_valid = 0;
   logic [3:0] req_yield_target = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_status;
   logic [3:0] rsp_next_partition;
   logic [63:0] rsp_held_mask;

   time_slot_scheduler_table_unit uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Predictor state.
   logic [4:0]  owner_of [NSLOT];
   logic [63:0] used_map, locked_map;
   logic [5:0]  slot_ptr;
   logic [63:0] held_of [NPART], required_of [NPART], desired_of [NPART];
   logic        runnable [NPART];

   request_type pending_reqs [$];
   grant_type   expected_grants [$];
   int errors = 0, grants_seen = 0, sched_picks = 0, param_fails = 0;
   longint cycle = 0;
   bit hold_rsp = 0;
   bit bursty = 0;
   logic req_taken = 1'b0;

   function automatic logic [63:0] rotl(logic [63:0] x, int r);
      if (r == 0) return x;
      return (x << r) | (x >> (NSLOT - r));
   endfunction

   function automatic int fit_rotation(logic [63:0] pat, logic [63:0] blocked);
      for (int r = 0; r < NSLOT; r++)
         if ((rotl(pat, r) & blocked) == 0) return r;
      return NSLOT;
   endfunction

   function automatic void free_slot(int i);
      if (owner_of[i] != 0) held_of[owner_of[i] - 1][i] = 1'b0;
      owner_of[i] = 0;
   endfunction

   function automatic void grab_slots(logic [63:0] m, int p);
      for (int i = 0; i < NSLOT; i++)
         if (m[i] && owner_of[i] != p + 1) begin
            free_slot(i);
            owner_of[i] = 5'(p + 1);
            held_of[p][i] = 1'b1;
         end
   endfunction

   function automatic grant_type predict_grant(request_type q);
      grant_type g;
      logic [63:0] mine, rq, ds;
      int r, p, s;
      g = '{1'b0, 4'd0, 64'd0};
      p = q.partition;
      case (q.kind)
         tsst_pkg::KIND_SET_PARAMS: begin
            mine = held_of[p];
            r = fit_rotation(q.required_mask, used_map & ~mine);
            if (r >= NSLOT) r = fit_rotation(q.required_mask, locked_map & ~mine);
            if (r >= NSLOT) begin
               g.status = 1'b1;
               param_fails++;
            end else begin
               rq = rotl(q.required_mask, r);
               ds = rotl(q.desired_mask, r);
               for (int i = 0; i < NSLOT; i++) if (mine[i]) free_slot(i);
               grab_slots(rq, p);
               locked_map &= ~(mine & required_of[p]);
               used_map &= ~mine;
               required_of[p] = rq;
               desired_of[p] = ds;
               locked_map |= rq;
               ds &= ~locked_map;
               grab_slots(ds, p);
               used_map |= ds | rq;
            end
         end
         tsst_pkg::KIND_MARK_READY: runnable[p] = 1'b1;
         tsst_pkg::KIND_PICK_NEXT: begin
            if (q.yield_valid && q.yield_target != q.partition) begin
               g.next_partition = q.yield_target;
            end else begin
               g.next_partition = q.partition;
               s = slot_ptr;
               for (int i = 0; i < NSLOT; i++) begin
                  s = (s + 1) % NSLOT;
                  if (owner_of[s] != 0 && runnable[owner_of[s] - 1]) begin
                     slot_ptr = 6'(s);
                     g.next_partition = 4'(owner_of[s] - 1);
                     sched_picks++;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      if (q.kind <= tsst_pkg::KIND_PICK_NEXT) g.held_mask = held_of[p];
      return g;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Sparse masks fit often; dense ones exercise the fallback and failure paths.
   function automatic logic [63:0] slot_pattern();
      logic [63:0] m;
      case ($urandom_range(5))
         0: m = rand64();
         1: m = 64'd0;
         2: m = rand64() & rand64() & rand64();
         default: begin
            m = 0;
            repeat ($urandom_range(4)) m[$urandom_range(63)] = 1'b1;
         end
      endcase
      return m;
   endfunction

   task automatic queue_req(logic [1:0] k, logic [3:0] p, logic [63:0] rm, logic [63:0] dm,
                            logic yv, logic [3:0] yt);
      request_type q;
      q = '{k, p, rm, dm, yv, yt};
      pending_reqs.push_back(q);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_grants.size() != 0)
         @(posedge clock);
   endtask

   // Driver: fill the channel from the queue, with a random gap per beat.
   always @(negedge clock) begin
      static int gap = 0;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (gap > 0) begin
               gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               request_type q;
               q = pending_reqs.pop_front();
               req_kind <= q.kind;
               req_partition <= q.partition;
               req_required_mask <= q.required_mask;
               req_desired_mask <= q.desired_mask;
               req_yield_valid <= q.yield_valid;
               req_yield_target <= q.yield_target;
               req_valid <= 1'b1;
               gap = bursty ? 0 : $urandom_range(15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Record accepted requests and predict, and check result beats, at the rising edge.
   always @(posedge clock) begin
      req_taken <= 1'b0;
      cycle++;
      if (cycle > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         request_type q;
         q = '{req_kind, req_partition, req_required_mask, req_desired_mask,
               req_yield_valid, req_yield_target};
         expected_grants.push_back(predict_grant(q));
         req_taken <= 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         grant_type e;
         grants_seen++;
         if (expected_grants.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
         end else begin
            e = expected_grants.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_next_partition !== e.next_partition) begin
               $error("next_partition: expected %0d, got %0d", e.next_partition,
                      rsp_next_partition);
               errors++;
            end
            if (rsp_held_mask !== e.held_mask) begin
               $error("held_mask: expected %h, got %h", e.held_mask, rsp_held_mask);
               errors++;
            end
         end
      end
   end

   // Receiver stall: random wait per beat, or a long counted hold-off when asked.
   always @(negedge clock) begin
      static int wait_left = 0;
      static int hold_left = 0;
      static bit hold_seen = 0;
      if (hold_rsp && !hold_seen) begin
         hold_seen = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (wait_left > 0) begin
         wait_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         // the offered beat is taken at the next rising edge
         if (rsp_valid && !bursty) wait_left = $urandom_range(15);
      end
   end

   initial begin
      for (int i = 0; i < NSLOT; i++) owner_of[i] = 0;
      for (int p = 0; p < NPART; p++) begin
         held_of[p] = 0; required_of[p] = 0; desired_of[p] = 0; runnable[p] = 0;
      end
      used_map = 0; locked_map = 0; slot_ptr = 0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: extremes, every kind, yield cases, fallback and failure.
      queue_req(tsst_pkg::KIND_PICK_NEXT, 4'd0, 64'd0, 64'd0, 1'b0, 4'd0); // nobody runnable
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd0, 64'h1, 64'h0, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd1, 64'h1, 64'h2, 1'b0, 4'd0); // rotation needed
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd2, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd15);                // no rotation fits
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd4, 64'h8000_0000_0000_0001, 64'h5, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_MARK_READY, 4'd0, 64'd0, 64'd0, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_MARK_READY, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd15);
      queue_req(tsst_pkg::KIND_PICK_NEXT, 4'd5, 64'd0, 64'd0, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_PICK_NEXT, 4'd5, 64'd0, 64'd0, 1'b1, 4'd5);  // yield to self
      queue_req(tsst_pkg::KIND_PICK_NEXT, 4'd5, 64'd0, 64'd0, 1'b1, 4'd15); // directed yield
      queue_req(tsst_pkg::KIND_PICK_NEXT, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0);
      queue_req(tsst_pkg::KIND_UNUSED, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd15);                // unknown kind
      queue_req(tsst_pkg::KIND_UNUSED, 4'd0, 64'd0, 64'd0, 1'b0, 4'd0);
      queue_req(tsst_pkg::KIND_SET_PARAMS, 4'd0, 64'h3, 64'hC, 1'b0, 4'd0); // frees old slots
      queue_req(tsst_pkg::KIND_PICK_NEXT, 4'd0, 64'd0, 64'd0, 1'b0, 4'd0);
      wait_drained();

      // Back-pressure: hold the result side while the sender keeps offering.
      bursty = 1;
      hold_rsp = 1;
      for (int n = 0; n < 12; n++)
         queue_req(2'($urandom_range(2)), 4'($urandom_range(15)), slot_pattern(),
                   slot_pattern(), 1'($urandom_range(1)), 4'($urandom_range(15)));
      wait_drained();
      hold_rsp = 0;
      bursty = 0;

      // Random: mostly set-params / ready / pick-next mixes, some unknown kinds.
      for (int n = 0; n < 1500; n++) begin
         int sel;
         logic [1:0] k;
         sel = $urandom_range(99);
         k = sel < 40 ? tsst_pkg::KIND_SET_PARAMS : sel < 55 ? tsst_pkg::KIND_MARK_READY :
             sel < 97 ? tsst_pkg::KIND_PICK_NEXT : tsst_pkg::KIND_UNUSED;
         queue_req(k, 4'($urandom_range(15)), slot_pattern(), slot_pattern(),
                   1'($urandom_range(1)), 4'($urandom_range(15)));
         if (n % 300 == 299) begin
            wait_drained();                                   // sender pause
            bursty = ($urandom_range(3) == 0);
         end
      end
      wait_drained();
      repeat (300) @(posedge clock);
      $display("Checked %0d result beats: %0d scheduled picks, %0d set-params refusals.",
               grants_seen, sched_picks, param_fails);
      if (errors == 0 && expected_grants.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/tsst_pkg.sv
rtl/core/tsst_ctrl.sv
rtl/core/tsst_dp.sv
rtl/core/time_slot_scheduler_table_unit.sv
tb/time_slot_scheduler_table_unit_tb.sv
